/* sv/rcs_pkg.sv */
// Shared types, codes and ring arithmetic for the rotating card stack.
package rcs_pkg;

    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int VAL_W = 32;

    localparam logic [1:0] ACT_PUSH     = 2'd0;
    localparam logic [1:0] ACT_POP      = 2'd1;
    localparam logic [1:0] ACT_TOP_DOWN = 2'd2;
    localparam logic [1:0] ACT_BOT_UP   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(DEPTH);

    typedef struct packed {
        logic [1:0]              action;
        logic signed [VAL_W-1:0] card_value;
    } rcs_in_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] popped_value;
        logic [6:0]              entries_held;
    } rcs_out_t;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ring_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? LAST_PTR : p - PTR_W'(1);
    endfunction

    // sum is below twice the depth
    function automatic logic [PTR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        r = (s >= DEPTH_SUM) ? s - DEPTH_SUM : s;
        return r[PTR_W-1:0];
    endfunction

endpackage

/* sv/rotating_card_stack.sv */
// Top level of the rotating card stack: pointer control, ring RAM and result register.
//
//  channel | direction | payload   | handshake
//  cmd     | in        | rcs_in_t  | cmd_valid / cmd_ready
//  rsp     | out       | rcs_out_t | rsp_valid / rsp_ready
//
// An item is accepted in S_IDLE, where the accept edge issues the ring read; in S_EXEC
// it writes back, moves the pointers and loads the result register.
// The registered read port of the ring RAM makes the S_EXEC state necessary.
// Reset clears the top pointer, the count and the state; ring contents are kept.
// A result waiting in the output register does not block the next accept; the
// write-back stalls only until that result is taken.
module rotating_card_stack (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rcs_pkg::rcs_in_t  cmd,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output rcs_pkg::rcs_out_t rsp
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic                              state_reg, state_next;
    logic [rcs_pkg::PTR_W-1:0]         top_reg, top_next;
    logic [rcs_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [1:0]                        op_reg;
    logic signed [rcs_pkg::VAL_W-1:0]  val_reg;
    logic                              rsp_valid_reg, rsp_valid_next;
    rcs_pkg::rcs_out_t                 rsp_reg, rsp_next;

    logic                              cmd_fire;
    logic                              finish;
    logic                              rd_en;
    logic [rcs_pkg::PTR_W-1:0]         rd_addr;
    logic [rcs_pkg::VAL_W-1:0]         rd_data;
    logic                              wr_en;
    logic [rcs_pkg::PTR_W-1:0]         wr_addr;
    logic [rcs_pkg::VAL_W-1:0]         wr_data;
    logic [rcs_pkg::PTR_W-1:0]         bottom;
    logic [rcs_pkg::PTR_W-1:0]         below_bottom;
    logic                              empty;
    logic                              full;

    assign cmd_ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign finish    = (state_reg == S_EXEC) && (!rsp_valid_reg || rsp_ready);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == rcs_pkg::FULL_COUNT);

    assign bottom = rcs_pkg::ring_wrap(rcs_pkg::SUM_W'(top_reg) + rcs_pkg::SUM_W'(count_reg)
                                       - rcs_pkg::SUM_W'(1));
    assign below_bottom = rcs_pkg::ring_wrap(rcs_pkg::SUM_W'(top_reg)
                                             + rcs_pkg::SUM_W'(count_reg));

    assign rd_en   = cmd_fire;
    assign rd_addr = (cmd.action == rcs_pkg::ACT_BOT_UP) ? bottom : top_reg;

    rcs_ram #(
        .WIDTH (rcs_pkg::VAL_W),
        .DEPTH (rcs_pkg::DEPTH),
        .AW    (rcs_pkg::PTR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        top_next   = top_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = top_reg;
        wr_data    = rd_data;
        rsp_next   = rsp_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (finish)
                begin
                    state_next            = S_IDLE;
                    rsp_next.status       = rcs_pkg::ST_DONE;
                    rsp_next.popped_value = '0;
                    if (op_reg == rcs_pkg::ACT_PUSH)
                    begin
                        if (full)
                        begin
                            rsp_next.status = rcs_pkg::ST_FULL;
                        end
                        else
                        begin
                            top_next   = rcs_pkg::ring_prev(top_reg);
                            count_next = count_reg + rcs_pkg::CNT_W'(1);
                            wr_en      = 1'b1;
                            wr_addr    = rcs_pkg::ring_prev(top_reg);
                            wr_data    = val_reg;
                        end
                    end
                    else if (empty)
                    begin
                        rsp_next.status = rcs_pkg::ST_EMPTY;
                    end
                    else if (op_reg == rcs_pkg::ACT_POP)
                    begin
                        rsp_next.popped_value = rd_data;
                        top_next   = rcs_pkg::ring_next(top_reg);
                        count_next = count_reg - rcs_pkg::CNT_W'(1);
                    end
                    else if (op_reg == rcs_pkg::ACT_TOP_DOWN)
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = below_bottom;
                        top_next = rcs_pkg::ring_next(top_reg);
                    end
                    else
                    begin
                        wr_en    = 1'b1;
                        wr_addr  = rcs_pkg::ring_prev(top_reg);
                        top_next = rcs_pkg::ring_prev(top_reg);
                    end
                    rsp_next.entries_held = 7'(count_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (cmd_fire)
        begin
            op_reg  <= cmd.action;
            val_reg <= cmd.card_value;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rcs_pkg::FULL_COUNT)
        else $error("held count above depth");

    a_rsp_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_reg.entries_held == 7'(count_reg))
        else $error("reported count differs from held count");

    a_popped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status != rcs_pkg::ST_DONE |-> rsp_reg.popped_value == '0)
        else $error("refused action returned a value");

    a_finish_one: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> rsp_valid_reg && state_reg == S_IDLE)
        else $error("finished item did not reach the result register");
`endif

endmodule

/* sv/rcs_ram.sv */
// Simple dual-port RAM, one write and one registered read port.
module rcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* tb/card_stack_checker.sv */
// Checker for the rotating card stack: predicts each result and compares it with the block.
`timescale 1ns / 100ps

module card_stack_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_ready,
    input  rcs_pkg::rcs_in_t  cmd,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  rcs_pkg::rcs_out_t rsp,
    output int                mismatches,
    output int                outstanding
);

    logic signed [rcs_pkg::VAL_W-1:0] deck [rcs_pkg::DEPTH];
    int                               deck_top;
    int                               deck_count;
    rcs_pkg::rcs_out_t                expected_results [$];
    int                               errs;

    // next state of the deck and the result of one action
    function automatic rcs_pkg::rcs_out_t apply_action(input rcs_pkg::rcs_in_t c);
        rcs_pkg::rcs_out_t r;
        int                slot;
        r = '0;
        r.status = rcs_pkg::ST_DONE;
        if (c.action == rcs_pkg::ACT_PUSH)
        begin
            if (deck_count == rcs_pkg::DEPTH)
            begin
                r.status = rcs_pkg::ST_FULL;
            end
            else
            begin
                deck_top = (deck_top + rcs_pkg::DEPTH - 1) % rcs_pkg::DEPTH;
                deck[deck_top] = c.card_value;
                deck_count++;
            end
        end
        else if (deck_count == 0)
        begin
            r.status = rcs_pkg::ST_EMPTY;
        end
        else if (c.action == rcs_pkg::ACT_POP)
        begin
            r.popped_value = deck[deck_top];
            deck_top = (deck_top + 1) % rcs_pkg::DEPTH;
            deck_count--;
        end
        else if (c.action == rcs_pkg::ACT_TOP_DOWN)
        begin
            slot = (deck_top + deck_count) % rcs_pkg::DEPTH;
            deck[slot] = deck[deck_top];
            deck_top = (deck_top + 1) % rcs_pkg::DEPTH;
        end
        else
        begin
            slot = (deck_top + deck_count - 1) % rcs_pkg::DEPTH;
            deck_top = (deck_top + rcs_pkg::DEPTH - 1) % rcs_pkg::DEPTH;
            deck[deck_top] = deck[slot];
        end
        r.entries_held = 7'(deck_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rcs_pkg::rcs_out_t want;
        if (!rst_n)
        begin
            deck_top = 0;
            deck_count = 0;
            expected_results.delete();
            errs = 0;
            mismatches <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: expected no result got %p", $time, rsp);
                    errs++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, rsp.status);
                        errs++;
                    end
                    if (rsp.popped_value !== want.popped_value)
                    begin
                        $display("%0t: popped_value expected %0d got %0d",
                                 $time, want.popped_value, rsp.popped_value);
                        errs++;
                    end
                    if (rsp.entries_held !== want.entries_held)
                    begin
                        $display("%0t: entries_held expected %0d got %0d",
                                 $time, want.entries_held, rsp.entries_held);
                        errs++;
                    end
                end
            end
            if (cmd_valid && cmd_ready)
            begin
                expected_results.push_back(apply_action(cmd));
            end
            mismatches <= errs;
            outstanding <= expected_results.size();
        end
    end

endmodule

/* tb/rotating_card_stack_tb.sv */
// Testbench top for the rotating card stack: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module rotating_card_stack_tb;

    localparam int ITEM_TARGET = 500;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 300;

    localparam int SEG_FILL  = 0;
    localparam int SEG_MIX   = 1;
    localparam int SEG_DRAIN = 2;

    logic              clk;
    logic              rst_n;
    logic              cmd_valid;
    logic              cmd_ready;
    rcs_pkg::rcs_in_t  cmd;
    logic              rsp_valid;
    logic              rsp_ready;
    rcs_pkg::rcs_out_t rsp;

    int       mismatches;
    int       outstanding;
    int       idle_cycles;
    int       cards_sent;
    int       send_calm;
    int       take_calm;

    rotating_card_stack dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    card_stack_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // wait per item, with runs of back-to-back items
    function automatic int draw_wait(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic signed [rcs_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic offer_card(input logic [1:0] act,
                              input logic signed [rcs_pkg::VAL_W-1:0] val);
        int gap;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd.action <= act;
        cmd.card_value <= val;
        do @(posedge clk); while (!(cmd_valid && cmd_ready));
        cards_sent++;
        @(negedge clk);
    endtask

    initial
    begin
        int         seg_no;
        int         seg_kind;
        int         seg_len;
        logic [1:0] act;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd = '0;
        cards_sent = 0;
        send_calm = 0;
        seg_no = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty stack, single-entry rotations, extremes
        offer_card(rcs_pkg::ACT_POP, 32'sd5);
        offer_card(rcs_pkg::ACT_TOP_DOWN, -32'sd1);
        offer_card(rcs_pkg::ACT_BOT_UP, 32'sh8000_0000);
        offer_card(rcs_pkg::ACT_PUSH, 32'sh7fff_ffff);
        offer_card(rcs_pkg::ACT_TOP_DOWN, '0);
        offer_card(rcs_pkg::ACT_BOT_UP, '0);
        offer_card(rcs_pkg::ACT_POP, '0);
        offer_card(rcs_pkg::ACT_PUSH, 32'sh8000_0000);
        offer_card(rcs_pkg::ACT_PUSH, '0);
        offer_card(rcs_pkg::ACT_PUSH, -32'sd1);
        offer_card(rcs_pkg::ACT_PUSH, 32'sh5555_5555);
        offer_card(rcs_pkg::ACT_TOP_DOWN, '0);
        offer_card(rcs_pkg::ACT_BOT_UP, '0);
        offer_card(rcs_pkg::ACT_TOP_DOWN, '0);
        offer_card(rcs_pkg::ACT_POP, '0);
        offer_card(rcs_pkg::ACT_POP, '0);
        offer_card(rcs_pkg::ACT_POP, '0);
        offer_card(rcs_pkg::ACT_POP, '0);
        offer_card(rcs_pkg::ACT_POP, 32'sh2aaa_aaaa);

        // fill, churn, drain, churn: full-ring pushes and rotations come from fill segments
        while (cards_sent < ITEM_TARGET)
        begin
            case (seg_no % 4)
                0:       seg_kind = SEG_FILL;
                2:       seg_kind = SEG_DRAIN;
                default: seg_kind = SEG_MIX;
            endcase
            seg_len = (seg_kind == SEG_MIX) ? $urandom_range(30, 80) : $urandom_range(90, 120);
            if (seg_len > ITEM_TARGET - cards_sent)
            begin
                seg_len = ITEM_TARGET - cards_sent;
            end
            repeat (seg_len)
            begin
                if (seg_kind == SEG_FILL)
                    act = ($urandom_range(0, 9) < 8) ? rcs_pkg::ACT_PUSH
                                                     : 2'($urandom_range(1, 3));
                else if (seg_kind == SEG_DRAIN)
                    act = ($urandom_range(0, 9) < 7) ? rcs_pkg::ACT_POP
                                                     : 2'($urandom_range(0, 3));
                else
                    act = 2'($urandom_range(0, 3));
                offer_card(act, pick_value());
            end
            seg_no++;
        end
        cmd_valid <= 1'b0;

        do @(posedge clk); while (outstanding != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // result side; one long hold-off lets the block back up into its input
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        take_calm = 0;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = (taken == HOLD_AFTER) ? HOLD_CYCLES : draw_wait(take_calm);
            if (stall > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            do @(posedge clk); while (!(rsp_valid && rsp_ready));
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial idle_cycles = 0;

endmodule
